// File: hw/rtl/tcc_pkg.sv
`default_nettype none

package tcc_pkg;

  localparam int unsigned SCREEN_WIDTH_DEF   = 128;
  localparam int unsigned SCREEN_HEIGHT_DEF  = 160;
  localparam int unsigned SHRINK_DIVISOR_DEF = 2;

  // serial operand / product width, CORDIC datapath and angle widths
  localparam int OPW          = 49;
  localparam int CW           = 52;
  localparam int ZW           = 25;
  localparam int CORDIC_STEPS = 20;

  localparam logic signed [ZW-1:0] PI_Q20      = 25'sd3294199;
  localparam logic signed [ZW-1:0] HALF_PI_Q20 = 25'sd1647099;
  localparam logic signed [CW-1:0] K_Q30       = 52'sd652032874;
  localparam logic signed [CW-1:0] NORM_LIMIT  = 52'sh100_0000_0000;
  localparam logic signed [15:0]   HALF_PI_Q13 = 16'sd12868;
  localparam logic signed [15:0]   PI_Q13      = 16'sd25736;

  typedef enum logic [2:0] {
    OP_MUL  = 3'b001,
    OP_SQRT = 3'b010,
    OP_DIV  = 3'b100
  } ser_op_t;

  typedef struct packed {
    logic                  go;
    ser_op_t               op;
    logic signed [OPW-1:0] opa;
    logic signed [16:0]    opb;
  } ser_req_t;

  typedef struct packed {
    logic                  done;
    logic signed [OPW-1:0] result;
  } ser_rsp_t;

  typedef struct packed {
    logic                  go;
    logic                  rotate;
    logic                  wide_lim;
    logic signed [OPW-1:0] x0;
    logic signed [OPW-1:0] y0;
    logic signed [15:0]    angle;
  } cor_req_t;

  typedef struct packed {
    logic               done;
    logic signed [15:0] angle;
    logic signed [31:0] cosv;
    logic signed [31:0] sinv;
  } cor_rsp_t;

  function automatic logic [19:0] atan_q20(input logic [4:0] i);
    logic [19:0] v;
    case (i)
      5'd0:    v = 20'd823550;
      5'd1:    v = 20'd486170;
      5'd2:    v = 20'd256879;
      5'd3:    v = 20'd130396;
      5'd4:    v = 20'd65451;
      5'd5:    v = 20'd32757;
      5'd6:    v = 20'd16383;
      5'd7:    v = 20'd8192;
      5'd8:    v = 20'd4096;
      5'd9:    v = 20'd2048;
      5'd10:   v = 20'd1024;
      5'd11:   v = 20'd512;
      5'd12:   v = 20'd256;
      5'd13:   v = 20'd128;
      5'd14:   v = 20'd64;
      5'd15:   v = 20'd32;
      5'd16:   v = 20'd16;
      5'd17:   v = 20'd8;
      5'd18:   v = 20'd4;
      5'd19:   v = 20'd2;
      default: v = 20'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/tcc_if.sv
`default_nettype none

interface tcc_sample_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;
  logic signed [15:0] mag_x;
  logic signed [15:0] mag_y;
  logic signed [15:0] mag_z;

  modport source(output valid, accel_x, accel_y, accel_z, mag_x, mag_y, mag_z,
                 input ready);
  modport sink(input valid, accel_x, accel_y, accel_z, mag_x, mag_y, mag_z,
               output ready);
endinterface

interface tcc_result_if;
  logic               valid;
  logic               ready;
  logic signed [14:0] pitch_angle;
  logic signed [14:0] roll_angle;
  logic signed [15:0] heading_angle;
  logic [7:0]         draw_x;
  logic [7:0]         draw_y;
  logic [7:0]         erase_x;
  logic [7:0]         erase_y;

  modport source(output valid, pitch_angle, roll_angle, heading_angle,
                 draw_x, draw_y, erase_x, erase_y, input ready);
  modport sink(input valid, pitch_angle, roll_angle, heading_angle,
               draw_x, draw_y, erase_x, erase_y, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/tcc_serial.sv
`default_nettype none

module tcc_serial #(
  parameter int unsigned SHRINK_DIVISOR = tcc_pkg::SHRINK_DIVISOR_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  tcc_pkg::ser_req_t req,
  output tcc_pkg::ser_rsp_t rsp
);
  import tcc_pkg::*;

  localparam int DVW  = $clog2(SHRINK_DIVISOR) + 2;
  localparam int RW   = 24;
  localparam int REMW = 28;
  localparam int QW   = 9;
  localparam logic [DVW-1:0] DIVISOR   = DVW'(SHRINK_DIVISOR);
  localparam logic [4:0]     MUL_LAST  = 5'd16;
  localparam logic [4:0]     SQRT_LAST = 5'(RW - 1);
  localparam logic [4:0]     DIV_LAST  = 5'(QW - 1);

  logic                  busy;
  logic                  done;
  ser_op_t               op;
  logic [4:0]            cnt;
  logic                  last;
  logic signed [OPW-1:0] acc;
  logic signed [OPW-1:0] sh;
  logic signed [16:0]    mb;
  logic [RW-1:0]         root;
  logic [REMW-1:0]       rem;
  logic [QW-1:0]         quo;
  logic [DVW-1:0]        drem;
  logic [REMW-1:0]       rem_sh;
  logic [REMW-1:0]       trial;
  logic [DVW-1:0]        dr_sh;

  always_comb begin
    unique case (op)
      OP_MUL:  last = (cnt == MUL_LAST);
      OP_SQRT: last = (cnt == SQRT_LAST);
      OP_DIV:  last = (cnt == DIV_LAST);
      default: last = 1'b1;
    endcase
    // two radicand bits per step, one dividend bit per step
    rem_sh = {rem[REMW-3:0], sh[OPW-2:OPW-3]};
    trial  = REMW'({root, 2'b01});
    dr_sh  = {drem[DVW-2:0], sh[QW-1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && last;
      if (req.go) begin
        busy <= 1'b1;
        op   <= req.op;
        cnt  <= '0;
        acc  <= '0;
        sh   <= req.opa;
        mb   <= req.opb;
        root <= '0;
        rem  <= '0;
        quo  <= '0;
        drem <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (last) begin
          busy <= 1'b0;
        end
        unique case (op)
          OP_MUL: begin
            // top multiplier bit carries negative weight
            if (mb[0]) begin
              acc <= last ? acc - sh : acc + sh;
            end
            sh <= sh <<< 1;
            mb <= mb >>> 1;
          end
          OP_SQRT: begin
            if (rem_sh >= trial) begin
              rem  <= rem_sh - trial;
              root <= {root[RW-2:0], 1'b1};
            end else begin
              rem  <= rem_sh;
              root <= {root[RW-2:0], 1'b0};
            end
            sh <= sh <<< 2;
          end
          OP_DIV: begin
            if (dr_sh >= DIVISOR) begin
              drem <= dr_sh - DIVISOR;
              quo  <= {quo[QW-2:0], 1'b1};
            end else begin
              drem <= dr_sh;
              quo  <= {quo[QW-2:0], 1'b0};
            end
            sh <= sh <<< 1;
          end
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    rsp.done = done;
    unique case (op)
      OP_MUL:  rsp.result = acc;
      OP_SQRT: rsp.result = OPW'(root);
      OP_DIV:  rsp.result = OPW'(quo);
      default: rsp.result = acc;
    endcase
  end

endmodule

`default_nettype wire

// File: hw/rtl/tcc_cordic.sv
`default_nettype none

module tcc_cordic (
  input  logic              clk,
  input  logic              rst,
  input  tcc_pkg::cor_req_t req,
  output tcc_pkg::cor_rsp_t rsp
);
  import tcc_pkg::*;

  typedef enum logic [3:0] {
    C_IDLE = 4'b0001,
    C_NORM = 4'b0010,
    C_ITER = 4'b0100,
    C_FIN  = 4'b1000
  } cst_t;

  localparam logic [4:0] LAST_STEP = 5'(CORDIC_STEPS - 1);

  cst_t                 state;
  logic                 rot;
  logic                 wlim;
  logic                 flip;
  logic                 done;
  logic [4:0]           step;
  logic signed [CW-1:0] x;
  logic signed [CW-1:0] y;
  logic signed [ZW-1:0] z;
  logic signed [15:0]   angle;
  logic signed [31:0]   cosv;
  logic signed [31:0]   sinv;

  logic signed [CW-1:0] x_in;
  logic signed [CW-1:0] y_in;
  logic signed [ZW-1:0] z_rot;
  logic signed [CW-1:0] xs;
  logic signed [CW-1:0] ys;
  logic signed [ZW-1:0] t;
  logic                 cw;
  logic                 in_range;
  logic signed [ZW-1:0] zr;
  logic signed [ZW-1:0] lim;
  logic signed [15:0]   sat;
  logic signed [CW-1:0] xo;
  logic signed [CW-1:0] yo;

  always_comb begin
    x_in     = CW'(req.x0);
    y_in     = CW'(req.y0);
    z_rot    = ZW'(req.angle) <<< 7;
    xs       = x >>> step;
    ys       = y >>> step;
    t        = ZW'(atan_q20(step));
    cw       = rot ? z[ZW-1] : !y[CW-1];
    in_range = (x < NORM_LIMIT) && (y < NORM_LIMIT) && (y > -NORM_LIMIT);
    zr       = (z + ZW'(64)) >>> 7;
    lim      = wlim ? ZW'(PI_Q13) : ZW'(HALF_PI_Q13);
    if (zr > lim) begin
      sat = lim[15:0];
    end else if (zr < -lim) begin
      sat = 16'(-lim);
    end else begin
      sat = zr[15:0];
    end
    xo = flip ? -x : x;
    yo = flip ? -y : y;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        C_IDLE: begin
          if (req.go) begin
            rot  <= req.rotate;
            wlim <= req.wide_lim;
            step <= '0;
            if (req.rotate) begin
              // fold into the half plane, flip the result back
              x     <= K_Q30;
              y     <= '0;
              state <= C_ITER;
              if (z_rot > HALF_PI_Q20) begin
                z    <= z_rot - PI_Q20;
                flip <= 1'b1;
              end else if (z_rot < -HALF_PI_Q20) begin
                z    <= z_rot + PI_Q20;
                flip <= 1'b1;
              end else begin
                z    <= z_rot;
                flip <= 1'b0;
              end
            end else begin
              flip <= 1'b0;
              if (x_in == '0 && y_in == '0) begin
                z     <= '0;
                state <= C_FIN;
              end else if (x_in < 0) begin
                x     <= -x_in;
                y     <= -y_in;
                z     <= (y_in >= 0) ? PI_Q20 : -PI_Q20;
                state <= C_NORM;
              end else begin
                x     <= x_in;
                y     <= y_in;
                z     <= '0;
                state <= C_NORM;
              end
            end
          end
        end
        C_NORM: begin
          if (in_range) begin
            x <= x <<< 1;
            y <= y <<< 1;
          end else begin
            state <= C_ITER;
          end
        end
        C_ITER: begin
          x    <= cw ? x + ys : x - ys;
          y    <= cw ? y - xs : y + xs;
          z    <= cw ? z + t : z - t;
          step <= step + 5'd1;
          if (step == LAST_STEP) begin
            state <= C_FIN;
          end
        end
        C_FIN: begin
          angle <= sat;
          cosv  <= xo[31:0];
          sinv  <= yo[31:0];
          done  <= 1'b1;
          state <= C_IDLE;
        end
        default: state <= C_IDLE;
      endcase
    end
  end

  assign rsp.done  = done;
  assign rsp.angle = angle;
  assign rsp.cosv  = cosv;
  assign rsp.sinv  = sinv;

endmodule

`default_nettype wire

// File: hw/rtl/tilt_compensated_compass.sv
// Tilt-compensated compass with moving-dot screen position.
// sample (sink): one request carries raw accelerometer and magnetometer
//   counts for three axes; it is taken when valid and ready are high.
// result (source): pitch and roll (signed Q2.13) and heading (signed Q3.13)
//   in radians, the new dot corner (draw_x/draw_y) and the corner drawn
//   before it (erase_x/erase_y), which the display clears.
// mode_we/mode_wdata: write display_mode (0 tilt dot, 1 compass dot);
//   write it only while no request is in flight.
// Run time is set by the bit-serial multiplier (thirteen products), the
//   bit-serial square root (twice), the serial shrink divide (twice) and
//   the shared CORDIC unit (20 steps, plus up to 40 normalising doublings
//   per arctangent).
// Throughput: one request at a time; ready is high only while idle.
// Reset: clears the sequencer, sets display_mode to tilt and the last dot
//   to the screen centre plus one.
// Stall: a finished result waits in the output register; a new request
//   is taken meanwhile and holds at its last step until the slot frees.
`default_nettype none

module tilt_compensated_compass #(
  parameter int unsigned SCREEN_WIDTH   = tcc_pkg::SCREEN_WIDTH_DEF,
  parameter int unsigned SCREEN_HEIGHT  = tcc_pkg::SCREEN_HEIGHT_DEF,
  parameter int unsigned SHRINK_DIVISOR = tcc_pkg::SHRINK_DIVISOR_DEF
) (
  input  logic          clk,
  input  logic          rst,
  tcc_sample_if.sink    sample,
  tcc_result_if.source  result,
  input  logic          mode_we,
  input  logic          mode_wdata
);
  import tcc_pkg::*;

  // one-hot sequencer, one state per arithmetic step
  typedef enum logic [24:0] {
    S_IDLE = 25'h000_0001,
    S_SQA  = 25'h000_0002,
    S_SQB  = 25'h000_0004,
    S_RTP  = 25'h000_0008,
    S_ATP  = 25'h000_0010,
    S_SQC  = 25'h000_0020,
    S_SQD  = 25'h000_0040,
    S_RTR  = 25'h000_0080,
    S_ATR  = 25'h000_0100,
    S_SCP  = 25'h000_0200,
    S_SCR  = 25'h000_0400,
    S_MXC  = 25'h000_0800,
    S_MZS  = 25'h000_1000,
    S_MXS  = 25'h000_2000,
    S_MTS  = 25'h000_4000,
    S_MYC  = 25'h000_8000,
    S_MZR  = 25'h001_0000,
    S_MTC  = 25'h002_0000,
    S_ATH  = 25'h004_0000,
    S_SCH  = 25'h008_0000,
    S_MDX  = 25'h010_0000,
    S_DVX  = 25'h020_0000,
    S_MDY  = 25'h040_0000,
    S_DVY  = 25'h080_0000,
    S_DONE = 25'h100_0000
  } state_t;

  localparam int HW = SCREEN_WIDTH / 2;
  localparam int HH = SCREEN_HEIGHT / 2;
  localparam logic signed [16:0] HW_B = 17'(HW);
  localparam logic signed [16:0] HH_B = 17'(HH);
  localparam logic [7:0] CX = 8'(HW + 1);
  localparam logic [7:0] CY = 8'(HH + 1);
  localparam int FRAC_ANG = 13;
  localparam int FRAC_COS = 30;

  state_t state;
  state_t nxt;
  logic   issued;
  logic   mode;
  logic   use_ser;
  logic   use_cor;
  logic   unit_done;

  ser_req_t sreq;
  ser_rsp_t srsp;
  cor_req_t creq;
  cor_rsp_t crsp;

  // held sample
  logic signed [15:0] ax, ay, az, mx, my, mz;

  // intermediate results
  logic [31:0]           sumsq;
  logic [23:0]           root;
  logic signed [15:0]    pitch, roll, heading;
  logic signed [16:0]    cp, sp, cr, sr;
  logic signed [31:0]    cq, sq;
  logic signed [31:0]    tmp;
  logic signed [33:0]    xacc;
  logic signed [OPW-1:0] yacc;
  logic                  sgn_x, sgn_y;
  logic [8:0]            mag_x, mag_y;
  logic [7:0]            q_x, q_y;
  logic [7:0]            last_x, last_y;

  logic signed [32:0]    cos_r, sin_r;
  logic [OPW-1:0]        pabs;
  logic [OPW-1:0]        pshift;
  logic [7:0]            dx, dy;

  tcc_serial #(
    .SHRINK_DIVISOR(SHRINK_DIVISOR)
  ) u_serial (
    .clk(clk),
    .rst(rst),
    .req(sreq),
    .rsp(srsp)
  );

  tcc_cordic u_cordic (
    .clk(clk),
    .rst(rst),
    .req(creq),
    .rsp(crsp)
  );

  assign sample.ready = (state == S_IDLE);

  // operand select and successor for each step
  always_comb begin
    sreq    = '0;
    creq    = '0;
    use_ser = 1'b0;
    use_cor = 1'b0;
    nxt     = state;
    sreq.op = OP_MUL;
    unique case (state)
      S_SQA: begin
        use_ser = 1'b1; sreq.opa = OPW'(ay); sreq.opb = 17'(ay); nxt = S_SQB;
      end
      S_SQB: begin
        use_ser = 1'b1; sreq.opa = OPW'(az); sreq.opb = 17'(az); nxt = S_RTP;
      end
      S_RTP: begin
        use_ser = 1'b1; sreq.op = OP_SQRT; sreq.opa = OPW'({sumsq, 16'h0000});
        nxt = S_ATP;
      end
      S_ATP: begin
        use_cor = 1'b1; creq.x0 = OPW'(root); creq.y0 = OPW'(ax) <<< 8;
        nxt = S_SQC;
      end
      S_SQC: begin
        use_ser = 1'b1; sreq.opa = OPW'(ax); sreq.opb = 17'(ax); nxt = S_SQD;
      end
      S_SQD: begin
        use_ser = 1'b1; sreq.opa = OPW'(az); sreq.opb = 17'(az); nxt = S_RTR;
      end
      S_RTR: begin
        use_ser = 1'b1; sreq.op = OP_SQRT; sreq.opa = OPW'({sumsq, 16'h0000});
        nxt = S_ATR;
      end
      S_ATR: begin
        use_cor = 1'b1; creq.x0 = OPW'(root); creq.y0 = OPW'(ay) <<< 8;
        nxt = S_SCP;
      end
      S_SCP: begin
        use_cor = 1'b1; creq.rotate = 1'b1; creq.angle = pitch; nxt = S_SCR;
      end
      S_SCR: begin
        use_cor = 1'b1; creq.rotate = 1'b1; creq.angle = roll; nxt = S_MXC;
      end
      S_MXC: begin
        use_ser = 1'b1; sreq.opa = OPW'(mx); sreq.opb = cp; nxt = S_MZS;
      end
      S_MZS: begin
        use_ser = 1'b1; sreq.opa = OPW'(mz); sreq.opb = sp; nxt = S_MXS;
      end
      S_MXS: begin
        use_ser = 1'b1; sreq.opa = OPW'(mx); sreq.opb = sr; nxt = S_MTS;
      end
      S_MTS: begin
        use_ser = 1'b1; sreq.opa = OPW'(tmp); sreq.opb = sp; nxt = S_MYC;
      end
      S_MYC: begin
        use_ser = 1'b1; sreq.opa = OPW'(my); sreq.opb = cr; nxt = S_MZR;
      end
      S_MZR: begin
        use_ser = 1'b1; sreq.opa = OPW'(mz); sreq.opb = sr; nxt = S_MTC;
      end
      S_MTC: begin
        use_ser = 1'b1; sreq.opa = OPW'(tmp); sreq.opb = cp; nxt = S_ATH;
      end
      S_ATH: begin
        use_cor = 1'b1; creq.wide_lim = 1'b1;
        creq.x0 = {xacc, 15'h0000}; creq.y0 = yacc;
        nxt = mode ? S_SCH : S_MDX;
      end
      S_SCH: begin
        use_cor = 1'b1; creq.rotate = 1'b1; creq.angle = heading; nxt = S_MDX;
      end
      S_MDX: begin
        use_ser = 1'b1; sreq.opa = mode ? OPW'(cq) : OPW'(roll); sreq.opb = HW_B;
        nxt = S_DVX;
      end
      S_DVX: begin
        use_ser = 1'b1; sreq.op = OP_DIV; sreq.opa = OPW'(mag_x); nxt = S_MDY;
      end
      S_MDY: begin
        use_ser = 1'b1; sreq.opa = mode ? OPW'(sq) : OPW'(pitch); sreq.opb = HH_B;
        nxt = S_DVY;
      end
      S_DVY: begin
        use_ser = 1'b1; sreq.op = OP_DIV; sreq.opa = OPW'(mag_y); nxt = S_DONE;
      end
      default: ;
    endcase
    sreq.go   = use_ser && !issued;
    creq.go   = use_cor && !issued;
    unit_done = (use_ser && srsp.done) || (use_cor && crsp.done);
  end

  // Q30 to Q15 with rounding; magnitude of a product taken to an integer
  always_comb begin
    cos_r  = (33'(crsp.cosv) + 33'sd16384) >>> 15;
    sin_r  = (33'(crsp.sinv) + 33'sd16384) >>> 15;
    pabs   = srsp.result[OPW-1] ? OPW'(-srsp.result) : OPW'(srsp.result);
    pshift = mode ? (pabs >> FRAC_COS) : (pabs >> FRAC_ANG);
    // tilt moves the dot against the offset, compass along it
    dx = ((mode ? sgn_x : !sgn_x) ? CX - q_x : CX + q_x);
    dy = ((mode ? sgn_y : !sgn_y) ? CY - q_y : CY + q_y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      issued       <= 1'b0;
      mode         <= 1'b0;
      last_x       <= CX;
      last_y       <= CY;
      result.valid <= 1'b0;
    end else begin
      if (mode_we) begin
        mode <= mode_wdata;
      end
      // drop valid once taken, unless the next result refills the slot
      if (result.valid && result.ready && state != S_DONE) begin
        result.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (sample.valid) begin
            ax    <= sample.accel_x;
            ay    <= sample.accel_y;
            az    <= sample.accel_z;
            mx    <= sample.mag_x;
            my    <= sample.mag_y;
            mz    <= sample.mag_z;
            state <= S_SQA;
          end
        end
        S_DONE: begin
          // hold until the output slot is free
          if (!result.valid || result.ready) begin
            result.valid         <= 1'b1;
            result.pitch_angle   <= pitch[14:0];
            result.roll_angle    <= roll[14:0];
            result.heading_angle <= heading;
            result.draw_x        <= dx;
            result.draw_y        <= dy;
            result.erase_x       <= last_x;
            result.erase_y       <= last_y;
            last_x               <= dx;
            last_y               <= dy;
            state                <= S_IDLE;
          end
        end
        default: begin
          if (!issued) begin
            issued <= 1'b1;
          end
          if (unit_done) begin
            issued <= 1'b0;
            state  <= nxt;
          end
        end
      endcase

      if (unit_done) begin
        unique case (state)
          S_SQA, S_SQC: sumsq <= srsp.result[31:0];
          S_SQB, S_SQD: sumsq <= sumsq + srsp.result[31:0];
          S_RTP, S_RTR: root <= srsp.result[23:0];
          S_ATP:        pitch <= crsp.angle;
          S_ATR:        roll <= crsp.angle;
          S_SCP: begin
            cp <= cos_r[16:0];
            sp <= sin_r[16:0];
          end
          S_SCR: begin
            cr <= cos_r[16:0];
            sr <= sin_r[16:0];
          end
          S_MXC:        xacc <= srsp.result[33:0];
          S_MZS:        xacc <= xacc + srsp.result[33:0];
          S_MXS, S_MZR: tmp <= srsp.result[31:0];
          S_MTS:        yacc <= srsp.result;
          S_MYC:        yacc <= yacc + (srsp.result <<< 15);
          S_MTC:        yacc <= yacc - srsp.result;
          S_ATH:        heading <= crsp.angle;
          S_SCH: begin
            cq <= crsp.cosv;
            sq <= crsp.sinv;
          end
          S_MDX: begin
            sgn_x <= srsp.result[OPW-1];
            mag_x <= pshift[8:0];
          end
          S_DVX:        q_x <= srsp.result[7:0];
          S_MDY: begin
            sgn_y <= srsp.result[OPW-1];
            mag_y <= pshift[8:0];
          end
          S_DVY:        q_y <= srsp.result[7:0];
          default: ;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

// File: dv/tcc_tb_pkg.sv
`timescale 1ns / 100ps

package tcc_tb_pkg;

  typedef enum logic {
    MODE_TILT    = 1'b0,
    MODE_COMPASS = 1'b1
  } dot_mode_t;

endpackage

// File: dv/tcc_checker.sv
`timescale 1ns / 100ps

module tcc_checker
  import tcc_tb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  tcc_sample_if      sample,
  tcc_result_if      result,
  input  logic       mode_we,
  input  logic       mode_wdata,
  output int         fail_count,
  output int         pending
);

  localparam longint PI_Q20  = 3294199;
  localparam longint HPI_Q20 = 1647099;
  localparam longint K_Q30   = 652032874;
  localparam longint NORM_LIM = 64'sd1 << 40;
  localparam longint HW = 64;
  localparam longint HH = 80;
  localparam longint SHRINK = 2;

  typedef struct {
    logic signed [14:0] pitch;
    logic signed [14:0] roll;
    logic signed [15:0] heading;
    logic [7:0]         draw_x;
    logic [7:0]         draw_y;
    logic [7:0]         erase_x;
    logic [7:0]         erase_y;
  } dot_report_t;

  dot_report_t expected_reports[$];
  dot_mode_t   mode;
  logic [7:0]  last_x, last_y;

  function automatic longint atan_step(int i);
    longint steps[20] = '{823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192,
                          4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2};
    return steps[i];
  endfunction

  function automatic longint int_root(longint unsigned n);
    longint unsigned r, bit_v;
    r = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > n) bit_v >>= 2;
    while (bit_v != 0) begin
      if (n >= r + bit_v) begin
        n -= r + bit_v;
        r = (r >> 1) + bit_v;
      end else begin
        r >>= 1;
      end
      bit_v >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic longint vector_angle(longint y, longint x, longint lim);
    longint z, xs, ys, r;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = (y <= 0) ? PI_Q20 : -PI_Q20;
    end
    while (x < NORM_LIM && (y < 0 ? -y : y) < NORM_LIM) begin
      x = x * 2;
      y = y * 2;
    end
    for (int i = 0; i < 20; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z += atan_step(i);
      end else begin
        x = x - ys;
        y = y + xs;
        z -= atan_step(i);
      end
    end
    r = (z + 64) >>> 7;
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  task automatic rotate_unit(input longint a13, output longint c, output longint s);
    longint z, x, y, xs, ys;
    bit flip;
    z = a13 * 128;
    x = K_Q30;
    y = 0;
    flip = 0;
    if (z > HPI_Q20) begin
      z -= PI_Q20;
      flip = 1;
    end else if (z < -HPI_Q20) begin
      z += PI_Q20;
      flip = 1;
    end
    for (int i = 0; i < 20; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys;
        y = y + xs;
        z -= atan_step(i);
      end else begin
        x = x + ys;
        y = y - xs;
        z += atan_step(i);
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  function automatic longint to_q15(longint v);
    return (v + 16384) >>> 15;
  endfunction

  task automatic predict_dot(input longint ax, ay, az, mx, my, mz);
    longint pitch, roll, heading, cp, sp, cr, sr, xh, yh, c, s, dx, dy;
    dot_report_t rep;
    pitch = vector_angle(ax * 256, int_root(longint'(ay * ay + az * az) << 16), 12868);
    roll  = vector_angle(ay * 256, int_root(longint'(ax * ax + az * az) << 16), 12868);
    rotate_unit(pitch, cp, sp);
    rotate_unit(roll, cr, sr);
    cp = to_q15(cp);
    sp = to_q15(sp);
    cr = to_q15(cr);
    sr = to_q15(sr);
    xh = (mx * cp + mz * sp) * 32768;
    yh = mx * sr * sp + my * cr * 32768 - mz * sr * cp;
    heading = vector_angle(yh, xh, 25736);
    if (mode == MODE_TILT) begin
      dx = HW - (roll * HW) / 8192 / SHRINK + 1;
      dy = HH - (pitch * HH) / 8192 / SHRINK + 1;
    end else begin
      rotate_unit(heading, c, s);
      dx = HW + (c * HW) / (64'sd1 << 30) / SHRINK + 1;
      dy = HH + (s * HH) / (64'sd1 << 30) / SHRINK + 1;
    end
    rep.pitch   = pitch[14:0];
    rep.roll    = roll[14:0];
    rep.heading = heading[15:0];
    rep.draw_x  = dx[7:0];
    rep.draw_y  = dy[7:0];
    rep.erase_x = last_x;
    rep.erase_y = last_y;
    last_x = dx[7:0];
    last_y = dy[7:0];
    expected_reports.push_back(rep);
  endtask

  always @(posedge clk) begin
    dot_report_t want;
    int errs;
    errs = 0;
    if (rst) begin
      mode = MODE_TILT;
      last_x = 8'(HW + 1);
      last_y = 8'(HH + 1);
      expected_reports.delete();
      fail_count <= 0;
    end else begin
      if (sample.valid && sample.ready)
        predict_dot(sample.accel_x, sample.accel_y, sample.accel_z,
                    sample.mag_x, sample.mag_y, sample.mag_z);
      if (result.valid && result.ready) begin
        if (expected_reports.size() == 0) begin
          $error("result with no request outstanding");
          errs++;
        end else begin
          want = expected_reports.pop_front();
          if (want.pitch !== result.pitch_angle) begin
            $error("pitch_angle expected %0d got %0d", want.pitch, result.pitch_angle);
            errs++;
          end
          if (want.roll !== result.roll_angle) begin
            $error("roll_angle expected %0d got %0d", want.roll, result.roll_angle);
            errs++;
          end
          if (want.heading !== result.heading_angle) begin
            $error("heading_angle expected %0d got %0d", want.heading,
                   result.heading_angle);
            errs++;
          end
          if (want.draw_x !== result.draw_x) begin
            $error("draw_x expected %0d got %0d", want.draw_x, result.draw_x);
            errs++;
          end
          if (want.draw_y !== result.draw_y) begin
            $error("draw_y expected %0d got %0d", want.draw_y, result.draw_y);
            errs++;
          end
          if (want.erase_x !== result.erase_x) begin
            $error("erase_x expected %0d got %0d", want.erase_x, result.erase_x);
            errs++;
          end
          if (want.erase_y !== result.erase_y) begin
            $error("erase_y expected %0d got %0d", want.erase_y, result.erase_y);
            errs++;
          end
        end
      end
      if (mode_we) mode = dot_mode_t'(mode_wdata);
      fail_count <= fail_count + errs;
    end
    pending <= expected_reports.size();
  end

endmodule

// File: dv/tb.sv
`timescale 1ns / 100ps

module tb;
  import tcc_tb_pkg::*;

  localparam int STALL_LIMIT = 5000;  // comfortably above worst latency plus stalls
  localparam int SETTLE = 700;        // a little beyond the worst-case latency

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic mode_we = 1'b0;
  logic mode_wdata = 1'b0;
  int   fail_count;
  int   pending;
  int   quiet_cycles = 0;
  bit   calm = 1'b0;      // no idling on either side while set
  bit   run_out = 1'b0;   // last part of the run: no idling at all
  int   ready_gap = 0;

  tcc_sample_if sample();
  tcc_result_if result();

  tilt_compensated_compass i_dut (
    .clk       (clk),
    .rst       (rst),
    .sample    (sample.sink),
    .result    (result.source),
    .mode_we   (mode_we),
    .mode_wdata(mode_wdata)
  );

  tcc_checker i_checker (
    .clk       (clk),
    .rst       (rst),
    .sample    (sample),
    .result    (result),
    .mode_we   (mode_we),
    .mode_wdata(mode_wdata),
    .fail_count(fail_count),
    .pending   (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    sample.valid = 1'b0;
    sample.accel_x = '0;
    sample.accel_y = '0;
    sample.accel_z = '0;
    sample.mag_x = '0;
    sample.mag_y = '0;
    sample.mag_z = '0;
    result.ready = 1'b0;
  end

  // Result side: stall in random bursts, hold ready high when calm or running out
  always @(posedge clk) begin
    if (rst || calm || run_out) begin
      result.ready <= 1'b1;
      ready_gap <= 0;
    end else if (ready_gap > 0) begin
      result.ready <= 1'b0;
      ready_gap <= ready_gap - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      result.ready <= 1'b0;
      ready_gap <= $urandom_range(0, 16);
    end else begin
      result.ready <= 1'b1;
    end
  end

  // Watchdog: give up when nothing moves on either channel for too long
  always @(posedge clk) begin
    if (rst || (sample.valid && sample.ready) || (result.valid && result.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Offer one request; ready is read at the falling edge to stay clear of the DUT update
  task automatic send(input logic signed [15:0] ax, ay, az, mx, my, mz);
    int gap;
    if (!calm && !run_out && $urandom_range(0, 6) == 0) begin
      gap = $urandom_range(1, 17);
      sample.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample.valid <= 1'b1;
    sample.accel_x <= ax;
    sample.accel_y <= ay;
    sample.accel_z <= az;
    sample.mag_x <= mx;
    sample.mag_y <= my;
    sample.mag_z <= mz;
    do @(negedge clk); while (!sample.ready);
    @(posedge clk);
  endtask

  // Drop valid and hold until every outstanding result is back
  task automatic drain();
    sample.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic set_mode(input dot_mode_t m);
    drain();
    repeat (SETTLE) @(posedge clk);
    mode_we <= 1'b1;
    mode_wdata <= m;
    @(posedge clk);
    mode_we <= 1'b0;
  endtask

  task automatic directed_set();
    send(0, 0, 0, 0, 0, 0);                 // zero vector everywhere
    send(-32768, -32768, -32768, -32768, -32768, -32768);
    send(32767, 32767, 32767, 32767, 32767, 32767);
    send(32767, 0, 0, 0, 0, 0);             // pitch at its limit
    send(-32768, 0, 0, 0, 0, 0);
    send(0, 32767, 0, 0, 32767, 0);         // roll at its limit
    send(0, -32768, 0, 0, 0, -32768);
    send(0, 0, 16384, 20000, 0, 0);         // level, pointing north
    send(0, 0, 16384, -20000, 0, 0);        // heading near +-pi
    send(0, 0, 16384, 0, 20000, 0);
    send(0, 0, -16384, 0, -20000, 500);
    send(-32768, 32767, -32768, 32767, -32768, 32767);
    send(1, -1, 1, -1, 1, -1);
  endtask

  // Sample: mostly gravity around 1g with small tilt and a moderate field, else fully random
  task automatic random_sample();
    logic signed [15:0] f[6];
    if ($urandom_range(0, 3) == 0) begin
      foreach (f[i]) f[i] = 16'($urandom);
    end else begin
      f[0] = 16'($signed($urandom_range(0, 16000)) - 8000);
      f[1] = 16'($signed($urandom_range(0, 16000)) - 8000);
      f[2] = 16'($signed($urandom_range(0, 4000)) + 14000);
      if ($urandom_range(0, 1)) f[2] = -f[2];
      for (int i = 3; i < 6; i++) f[i] = 16'($signed($urandom_range(0, 8000)) - 4000);
    end
    send(f[0], f[1], f[2], f[3], f[4], f[5]);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed requests in both dot modes; the switch between them checks erase across modes
    set_mode(MODE_TILT);
    directed_set();
    set_mode(MODE_COMPASS);
    directed_set();

    // Random phases, alternating modes, with calm stretches
    for (int phase = 0; phase < 6; phase++) begin
      set_mode(phase[0] ? MODE_COMPASS : MODE_TILT);
      for (int n = 0; n < 120; n++) begin
        if (n % 40 == 0) calm = ($urandom_range(0, 3) == 0);
        if (n == 60 && phase == 2) drain();   // hold off until everything is back
        random_sample();
      end
    end

    // Final stretch with no idling
    calm = 1'b0;
    run_out = 1'b1;
    for (int n = 0; n < 30; n++) random_sample();
    drain();
    repeat (SETTLE) @(posedge clk);

    if (fail_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
